// ----- rtl/pending_signal_controller_defines.svh -----
// assertion macros for the pending signal controller checker
`ifndef PENDING_SIGNAL_CONTROLLER_DEFINES_SVH
`define PENDING_SIGNAL_CONTROLLER_DEFINES_SVH

// checked outside reset
`define PSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define PSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/psc_pkg.sv -----
// shared types and constants of the pending signal controller
package psc_pkg;

  localparam int unsigned DATA_W  = 48;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned SIG_W   = 5;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IDX_W   = 1;

  localparam int unsigned SIGNAL_COUNT_DEF = 32;
  localparam int unsigned ADDR_BITS_DEF    = 48;

  localparam logic [OP_W-1:0] OP_DELIVER = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_RETURN  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PENDING  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_ENTRY = 2'd2;

  localparam logic [IDX_W-1:0] CFG_ENTRY_ADDRESS = 1'b0;
  localparam logic [IDX_W-1:0] CFG_ENTRY_VALID   = 1'b1;

  typedef struct packed {
    logic load;
    logic exec;
  } psc_cmd_t;

endpackage

// ----- rtl/pending_signal_controller.sv -----
// top level of the pending signal controller
// the input is captured, then the result is registered in the execute step once the output slot is free
// a new item is not taken until the current one has passed the capture and execute steps
// a finished result waits in the output registers while the next item is taken
// reset: asynchronous, clears the signal state, configuration and the result valid
module pending_signal_controller #(
  parameter int unsigned SIGNAL_COUNT = psc_pkg::SIGNAL_COUNT_DEF,
  parameter int unsigned ADDR_BITS    = psc_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [psc_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [psc_pkg::DATA_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [psc_pkg::OP_W-1:0]    opcode_i,
  input  logic [psc_pkg::SIG_W-1:0]   signal_number_i,
  input  logic                        coalesce_i,
  input  logic [psc_pkg::DATA_W-1:0]  current_ip_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [psc_pkg::STAT_W-1:0]  status_o,
  output logic [psc_pkg::DATA_W-1:0]  next_ip_o,
  output logic                        redirected_o,
  output logic [psc_pkg::COUNT_W-1:0] lowest_pending_o,
  output logic [psc_pkg::DATA_W-1:0]  saved_return_ip_o,
  output logic [psc_pkg::COUNT_W-1:0] pending_total_o
);
  import psc_pkg::*;

  psc_cmd_t cmd;

  psc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  psc_datapath #(
    .SIGNAL_COUNT (SIGNAL_COUNT),
    .ADDR_BITS    (ADDR_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .opcode_i          (opcode_i),
    .signal_number_i   (signal_number_i),
    .coalesce_i        (coalesce_i),
    .current_ip_i      (current_ip_i),
    .status_o          (status_o),
    .next_ip_o         (next_ip_o),
    .redirected_o      (redirected_o),
    .lowest_pending_o  (lowest_pending_o),
    .saved_return_ip_o (saved_return_ip_o),
    .pending_total_o   (pending_total_o)
  );

endmodule

// ----- rtl/psc_ctrl.sv -----
// controller: input capture and result slot sequencing
module psc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psc_pkg::psc_cmd_t cmd_o
);
  import psc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/psc_datapath.sv -----
// datapath: signal state, configuration and result registers
module psc_datapath #(
  parameter int unsigned SIGNAL_COUNT = psc_pkg::SIGNAL_COUNT_DEF,
  parameter int unsigned ADDR_BITS    = psc_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  psc_pkg::psc_cmd_t              cmd_i,
  input  logic                           cfg_we_i,
  input  logic [psc_pkg::IDX_W-1:0]      cfg_index_i,
  input  logic [psc_pkg::DATA_W-1:0]     cfg_wdata_i,
  input  logic [psc_pkg::OP_W-1:0]       opcode_i,
  input  logic [psc_pkg::SIG_W-1:0]      signal_number_i,
  input  logic                           coalesce_i,
  input  logic [psc_pkg::DATA_W-1:0]     current_ip_i,
  output logic [psc_pkg::STAT_W-1:0]     status_o,
  output logic [psc_pkg::DATA_W-1:0]     next_ip_o,
  output logic                           redirected_o,
  output logic [psc_pkg::COUNT_W-1:0]    lowest_pending_o,
  output logic [psc_pkg::DATA_W-1:0]     saved_return_ip_o,
  output logic [psc_pkg::COUNT_W-1:0]    pending_total_o
);
  import psc_pkg::*;

  localparam int unsigned KeepW = (ADDR_BITS < DATA_W) ? ADDR_BITS : DATA_W;
  localparam logic [COUNT_W-1:0] NoneCode = COUNT_W'(SIGNAL_COUNT);

  // captured item
  logic [OP_W-1:0]   op_q;
  logic [SIG_W-1:0]  sig_q;
  logic              coal_q;
  logic [DATA_W-1:0] cur_q;

  // configuration
  logic [KeepW-1:0]  entry_q;
  logic              entry_valid_q;

  // signal state
  logic [SIGNAL_COUNT-1:0] bits_q, bits_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  logic                    handler_q, handler_d;
  logic [KeepW-1:0]        saved_q, saved_d;

  // result
  logic [STAT_W-1:0]  status_q, status_d;
  logic [DATA_W-1:0]  next_q, next_d;
  logic               redir_q, redir_d;
  logic [COUNT_W-1:0] lowest_q, lowest_d;

  logic [SIGNAL_COUNT-1:0] hot;
  logic                    in_range;
  logic                    hit;

  always_comb begin
    for (int i = 0; i < SIGNAL_COUNT; i++) begin
      hot[i] = (int'(sig_q) == i);
    end
  end

  assign in_range = |hot;
  assign hit      = |(bits_q & hot);

  always_comb begin
    bits_d    = bits_q;
    count_d   = count_q;
    handler_d = handler_q;
    saved_d   = saved_q;
    status_d  = STAT_OK;
    next_d    = cur_q;
    redir_d   = 1'b0;
    case (op_q)
      OP_DELIVER: begin
        if (in_range) begin
          if (hit) begin
            if (!coal_q) begin
              status_d = STAT_PENDING;
            end
          end else begin
            bits_d  = bits_q | hot;
            count_d = count_q + COUNT_W'(1);
          end
        end
      end
      OP_ACK: begin
        handler_d = 1'b0;
        if (hit) begin
          bits_d  = bits_q & ~hot;
          count_d = count_q - COUNT_W'(1);
        end
      end
      OP_RETURN: begin
        if ((count_q != '0) && !handler_q) begin
          if (!entry_valid_q) begin
            status_d = STAT_NO_ENTRY;
          end else begin
            saved_d   = KeepW'(cur_q);
            next_d    = DATA_W'(entry_q);
            handler_d = 1'b1;
            redir_d   = 1'b1;
          end
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
  end

  // lowest set bit of the updated bitmap
  always_comb begin
    lowest_d = NoneCode;
    for (int i = SIGNAL_COUNT - 1; i >= 0; i--) begin
      if (bits_d[i]) begin
        lowest_d = COUNT_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      sig_q  <= signal_number_i;
      coal_q <= coalesce_i;
      cur_q  <= current_ip_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      next_q   <= next_d;
      redir_q  <= redir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q       <= '0;
      entry_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ENTRY_ADDRESS) begin
        entry_q <= KeepW'(cfg_wdata_i);
      end
      if (cfg_index_i == CFG_ENTRY_VALID) begin
        entry_valid_q <= cfg_wdata_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q    <= '0;
      count_q   <= '0;
      handler_q <= 1'b0;
      saved_q   <= '0;
      lowest_q  <= NoneCode;
    end else if (cmd_i.exec) begin
      bits_q    <= bits_d;
      count_q   <= count_d;
      handler_q <= handler_d;
      saved_q   <= saved_d;
      lowest_q  <= lowest_d;
    end
  end

  assign status_o          = status_q;
  assign next_ip_o         = next_q;
  assign redirected_o      = redir_q;
  assign lowest_pending_o  = lowest_q;
  assign saved_return_ip_o = DATA_W'(saved_q);
  assign pending_total_o   = count_q;

endmodule

// ----- rtl/psc_checker.sv -----
// port level checks of the pending signal controller, bound to the top level
`include "pending_signal_controller_defines.svh"

module psc_checker #(
  parameter int unsigned SIGNAL_COUNT = psc_pkg::SIGNAL_COUNT_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [psc_pkg::STAT_W-1:0]  status_o,
  input logic [psc_pkg::DATA_W-1:0]  next_ip_o,
  input logic                        redirected_o,
  input logic [psc_pkg::COUNT_W-1:0] lowest_pending_o,
  input logic [psc_pkg::DATA_W-1:0]  saved_return_ip_o,
  input logic [psc_pkg::COUNT_W-1:0] pending_total_o
);
  import psc_pkg::*;

  localparam logic [COUNT_W-1:0] NoneCode = COUNT_W'(SIGNAL_COUNT);

  `PSC_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |-> !out_valid_o,
    "result valid during reset")

  `PSC_ASSERT(a_held_result,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(next_ip_o)
      && $stable(saved_return_ip_o) && $stable(pending_total_o),
    "stalled result changed")

  `PSC_ASSERT(a_empty_none,
    out_valid_o && (pending_total_o == '0) |-> lowest_pending_o == NoneCode,
    "no pending signal but lowest is set")

  `PSC_ASSERT(a_redirect_ok,
    out_valid_o && redirected_o |-> (status_o == STAT_OK) && (pending_total_o != '0),
    "redirect without pending signal or with error")

  `PSC_ASSERT(a_error_no_redirect, out_valid_o && (status_o != STAT_OK) |-> !redirected_o,
    "error result marked redirected")

endmodule

bind pending_signal_controller psc_checker #(
  .SIGNAL_COUNT (SIGNAL_COUNT)
) u_psc_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the pending signal controller
module testbench;
  import psc_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam int unsigned       SIG_TOTAL   = SIGNAL_COUNT_DEF;
  localparam int unsigned       IDLE_LIMIT  = 1000;
  localparam int unsigned       HOLD_CYCLES = 80;
  localparam logic [DATA_W-1:0] ADDR_ONES   = '1;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  next_ip;
    logic               redirected;
    logic [COUNT_W-1:0] lowest;
    logic [DATA_W-1:0]  saved_ip;
    logic [COUNT_W-1:0] total;
  } psc_result_t;

  class psc_scoreboard;
    logic [SIG_TOTAL-1:0]   pending_map  = '0;
    logic [COUNT_W-1:0]     pending_cnt  = '0;
    logic                   handler_busy = 1'b0;
    logic [DATA_W-1:0]      saved_addr   = '0;
    logic [DATA_W-1:0]      entry_addr   = '0;
    logic                   entry_ok     = 1'b0;
    psc_result_t            result_queue[$];
    int unsigned failures   = 0;
    int unsigned requests   = 0;
    int unsigned redirects  = 0;
    int unsigned rejects    = 0;
    int unsigned no_entry   = 0;
    int unsigned peak_count = 0;

    function void write_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_ENTRY_ADDRESS: entry_addr = data[ADDR_BITS_DEF-1:0];
        CFG_ENTRY_VALID:   entry_ok = data[0];
        default: ;
      endcase
    endfunction

    function logic [COUNT_W-1:0] lowest_pending_of(logic [SIG_TOTAL-1:0] map);
      for (int i = 0; i < SIG_TOTAL; i++)
        if (map[i]) return COUNT_W'(i);
      return COUNT_W'(SIG_TOTAL);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [SIG_W-1:0] sig, logic coal,
                               logic [DATA_W-1:0] ip);
      psc_result_t r;
      r.status     = STAT_OK;
      r.next_ip    = ip;
      r.redirected = 1'b0;
      case (op)
        OP_DELIVER: begin
          if (sig < SIG_TOTAL) begin
            if (pending_map[sig]) begin
              if (!coal) begin
                r.status = STAT_PENDING;
                rejects++;
              end
            end else begin
              pending_map[sig] = 1'b1;
              pending_cnt = pending_cnt + 1'b1;
            end
          end
        end
        OP_ACK: begin
          handler_busy = 1'b0;
          if (sig < SIG_TOTAL && pending_map[sig]) begin
            pending_map[sig] = 1'b0;
            pending_cnt = pending_cnt - 1'b1;
          end
        end
        OP_RETURN: begin
          if (pending_cnt != 0 && !handler_busy) begin
            if (!entry_ok) begin
              r.status = STAT_NO_ENTRY;
              no_entry++;
            end else begin
              saved_addr   = ip[ADDR_BITS_DEF-1:0];
              r.next_ip    = entry_addr;
              r.redirected = 1'b1;
              handler_busy = 1'b1;
              redirects++;
            end
          end
        end
        default: ;
      endcase
      r.lowest   = lowest_pending_of(pending_map);
      r.saved_ip = saved_addr;
      r.total    = pending_cnt;
      if (32'(pending_cnt) > peak_count) peak_count = 32'(pending_cnt);
      requests++;
      result_queue.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [DATA_W-1:0] next_ip,
                               logic redirected, logic [COUNT_W-1:0] lowest,
                               logic [DATA_W-1:0] saved_ip, logic [COUNT_W-1:0] total);
      psc_result_t want;
      if (result_queue.size() == 0) begin
        $error("result transfer with no request outstanding");
        failures++;
        return;
      end
      want = result_queue.pop_front();
      compare_field("status", want.status, status);
      compare_field("next_ip", want.next_ip, next_ip);
      compare_field("redirected", want.redirected, redirected);
      compare_field("lowest_pending", want.lowest, lowest);
      compare_field("saved_return_ip", want.saved_ip, saved_ip);
      compare_field("pending_total", want.total, total);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni          = 1'b1;
  logic                cfg_we_i        = 1'b0;
  logic [IDX_W-1:0]    cfg_index_i     = '0;
  logic [DATA_W-1:0]   cfg_wdata_i     = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     opcode_i        = '0;
  logic [SIG_W-1:0]    signal_number_i = '0;
  logic                coalesce_i      = 1'b0;
  logic [DATA_W-1:0]   current_ip_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic [DATA_W-1:0]   next_ip_o;
  logic                redirected_o;
  logic [COUNT_W-1:0]  lowest_pending_o;
  logic [DATA_W-1:0]   saved_return_ip_o;
  logic [COUNT_W-1:0]  pending_total_o;

  psc_scoreboard sb = new;
  bit            quiet        = 1'b0;
  bit            hold_request = 1'b0;
  int unsigned   idle_cycles  = 0;

  pending_signal_controller u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [DATA_W-1:0] rand_addr();
    logic [63:0] word = {$urandom, $urandom};
    return word[DATA_W-1:0];
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [SIG_W-1:0] sig,
                           input logic coal, input logic [DATA_W-1:0] ip);
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    signal_number_i <= sig;
    coalesce_i      <= coal;
    current_ip_i    <= ip;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, sig, coal, ip);
  endtask

  task automatic pause_input(input int unsigned cycles);
    in_valid_i      <= 1'b0;
    opcode_i        <= OP_W'($urandom);
    signal_number_i <= SIG_W'($urandom);
    coalesce_i      <= 1'($urandom);
    current_ip_i    <= rand_addr();
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_block();
    pause_input(1);
    while (sb.result_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_entry(input logic [DATA_W-1:0] addr, input logic valid);
    logic [DATA_W-1:0] flag_word;
    flag_word    = rand_addr();
    flag_word[0] = valid;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ENTRY_ADDRESS;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_index_i <= CFG_ENTRY_VALID;
    cfg_wdata_i <= flag_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_register(CFG_ENTRY_ADDRESS, addr);
    sb.write_register(CFG_ENTRY_VALID, flag_word);
  endtask

  task automatic random_items(input int unsigned count, input int unsigned deliver_pct,
                              input int unsigned ack_pct, input bit with_hold);
    int unsigned     pick;
    logic [OP_W-1:0] op;
    logic [SIG_W-1:0] sig;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < deliver_pct) op = OP_DELIVER;
      else if (pick < deliver_pct + ack_pct) op = OP_ACK;
      else if (pick < 96) op = OP_RETURN;
      else op = OP_UNUSED;
      // half the signals come from a narrow set so repeats and clears collide
      if ($urandom_range(1)) sig = SIG_W'($urandom);
      else if ($urandom_range(1)) sig = SIG_W'($urandom_range(3));
      else sig = 5'd28 + 5'($urandom_range(3));
      if (with_hold && n == count / 2) hold_request = 1'b1;
      send_item(op, sig, 1'($urandom_range(1)), rand_addr());
      if (!quiet && $urandom_range(99) < 12) pause_input($urandom_range(13, 1));
    end
  endtask

  // receiver side stall pattern
  initial begin
    int unsigned span;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (quiet || $urandom_range(2) != 0) begin
        out_stall_i <= 1'b0;
        span = quiet ? 1 : $urandom_range(30, 1);
        repeat (span) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(13, 1)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, next_ip_o, redirected_o, lowest_pending_o,
                      saved_return_ip_o, pending_total_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: no entry point
    send_item(OP_RETURN, 5'd0, 1'b0, '0);
    send_item(OP_DELIVER, 5'd0, 1'b0, '0);
    send_item(OP_DELIVER, 5'd0, 1'b0, ADDR_ONES);
    send_item(OP_DELIVER, 5'd0, 1'b1, '0);
    send_item(OP_DELIVER, 5'd31, 1'b1, ADDR_ONES);
    send_item(OP_RETURN, 5'd31, 1'b1, ADDR_ONES);
    send_item(OP_UNUSED, 5'd31, 1'b1, ADDR_ONES);
    send_item(OP_ACK, 5'd5, 1'b0, '0);
    drain_block();

    write_entry(ADDR_ONES, 1'b1);
    send_item(OP_RETURN, 5'd0, 1'b0, 48'h5555_5555_5555);
    send_item(OP_RETURN, 5'd0, 1'b0, 48'h1234_5678_9abc);
    send_item(OP_DELIVER, 5'd17, 1'b0, '0);
    send_item(OP_ACK, 5'd0, 1'b0, '0);
    send_item(OP_RETURN, 5'd10, 1'b1, 48'haaaa_aaaa_aaaa);
    send_item(OP_ACK, 5'd31, 1'b1, ADDR_ONES);
    send_item(OP_ACK, 5'd17, 1'b0, '0);
    send_item(OP_RETURN, 5'd0, 1'b0, ADDR_ONES);
    drain_block();

    write_entry(rand_addr(), 1'b1);
    random_items(190, 45, 25, 1'b0);
    drain_block();
    write_entry('0, 1'b1);
    random_items(190, 60, 15, 1'b1);
    drain_block();
    write_entry(rand_addr(), 1'b0);
    random_items(190, 45, 25, 1'b0);
    drain_block();
    write_entry(ADDR_ONES, 1'b1);
    random_items(190, 25, 50, 1'b0);
    drain_block();
    quiet = 1'b1;
    write_entry(rand_addr(), 1'b1);
    random_items(170, 45, 25, 1'b0);

    pause_input(1);
    while (sb.result_queue.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d transfers: %0d handler diversions,", sb.requests, sb.redirects);
    $display("%0d duplicate deliveries, %0d returns without entry point, peak pending %0d of %0d",
             sb.rejects, sb.no_entry, sb.peak_count, SIG_TOTAL);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_ctrl.sv
rtl/psc_datapath.sv
rtl/pending_signal_controller.sv
rtl/psc_checker.sv
test/testbench.sv
